// ===== design/i2a_pkg.sv =====
// shared types, constants and helpers for the integer to ascii formatter
package i2a_pkg;

    localparam int VALUE_W         = 64;
    localparam int CMD_W           = 2;
    localparam int CHAR_W          = 8;
    localparam int DIGIT_W         = 4;
    localparam int DIGIT_SLOTS_DEF = 20;

    // double-dabble conversion retires this many operand bits per cycle
    localparam int BITS_PER_STEP = 2;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(CONV_STEPS);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h37;

    typedef enum logic [CMD_W-1:0] {
        CMD_UDEC = 2'd0,
        CMD_SDEC = 2'd1,
        CMD_HEX  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_PRE0,
        ST_PRE1,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic load_dec;
        logic load_hex;
        logic step;
    } t_unit_ctl;

    // upper-case hex glyph for a digit value
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        return (d < 4'd10) ? (CH_ZERO + ext) : (CH_ALPHA + ext);
    endfunction

endpackage

// ===== design/i2a_in_if.sv =====
// input channel: conversion mode and operand
interface i2a_in_if;
    logic                          valid;
    logic                          ready;
    logic [i2a_pkg::CMD_W-1:0]     cmd;
    logic [i2a_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== design/i2a_out_if.sv =====
// output channel: one ascii character and end-of-number flag
interface i2a_out_if;
    logic                          valid;
    logic                          ready;
    logic [i2a_pkg::CHAR_W-1:0]    ch;
    logic                          last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== design/i2a_bcd_unit.sv =====
// shared shift-and-add-3 unit holding the digit store
module i2a_bcd_unit #(
    parameter int DIGIT_SLOTS = i2a_pkg::DIGIT_SLOTS_DEF,
    localparam int IDX_W     = $clog2(DIGIT_SLOTS),
    localparam int STORE_W   = DIGIT_SLOTS * i2a_pkg::DIGIT_W
) (
    input  logic                          i_clk,
    input  i2a_pkg::t_unit_ctl            i_ctl,
    input  logic [i2a_pkg::VALUE_W-1:0]   i_value,
    input  logic [IDX_W-1:0]              i_sel,
    output logic [i2a_pkg::DIGIT_W-1:0]   o_digit
);

    logic [STORE_W-1:0]            r_digits;
    logic [i2a_pkg::VALUE_W-1:0]   r_work;
    logic [STORE_W-1:0]            n_digits;
    logic [i2a_pkg::VALUE_W-1:0]   n_work;

    // BITS_PER_STEP dependent adjust-and-shift passes on the 4-bit digits
    always_comb begin
        n_digits = r_digits;
        n_work   = r_work;
        for (int b = 0; b < i2a_pkg::BITS_PER_STEP; b++) begin
            for (int i = 0; i < DIGIT_SLOTS; i++) begin
                if (n_digits[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] >= 4'd5) begin
                    n_digits[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] =
                        n_digits[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] + 4'd3;
                end
            end
            n_digits = {n_digits[STORE_W-2:0], n_work[i2a_pkg::VALUE_W-1]};
            n_work   = {n_work[i2a_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load_hex) begin
            r_digits <= {{(STORE_W-i2a_pkg::VALUE_W){1'b0}}, i_value};
        end else if (i_ctl.load_dec) begin
            r_digits <= '0;
            r_work   <= i_value;
        end else if (i_ctl.step) begin
            r_digits <= n_digits;
            r_work   <= n_work;
        end
    end

    assign o_digit = r_digits[i_sel*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W];

endmodule

// ===== design/i2a_seq.sv =====
// sequencer: accepts a number, steps the shared unit, emits characters
module i2a_seq #(
    parameter int DIGIT_SLOTS = i2a_pkg::DIGIT_SLOTS_DEF,
    localparam int IDX_W     = $clog2(DIGIT_SLOTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    i2a_in_if.sink                        i_in,
    i2a_out_if.source                     o_out,
    output i2a_pkg::t_unit_ctl            o_ctl,
    output logic [i2a_pkg::VALUE_W-1:0]   o_value,
    output logic [IDX_W-1:0]              o_sel,
    input  logic [i2a_pkg::DIGIT_W-1:0]   i_digit
);

    i2a_pkg::t_state                  r_state, n_state;
    logic [i2a_pkg::STEP_CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]                 r_idx, n_idx;
    logic                             r_hex, n_hex;
    logic                             r_neg, n_neg;
    logic                             r_out_valid;
    logic [i2a_pkg::CHAR_W-1:0]       r_ch;
    logic                             r_last;

    logic                             accept;
    logic                             out_free;
    logic                             emit;
    logic [i2a_pkg::CHAR_W-1:0]       emit_ch;
    logic                             emit_last;
    i2a_pkg::t_cmd                    cmd;
    logic                             in_neg;

    assign cmd      = i2a_pkg::t_cmd'(i_in.cmd);
    assign accept   = i_in.valid && (r_state == i2a_pkg::ST_IDLE);
    assign out_free = !r_out_valid || o_out.ready;
    assign in_neg   = (cmd == i2a_pkg::CMD_SDEC) && i_in.value[i2a_pkg::VALUE_W-1];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2a_pkg::ST_IDLE: begin
                if (accept && cmd != i2a_pkg::CMD_NONE) begin
                    n_state = (cmd == i2a_pkg::CMD_HEX) ? i2a_pkg::ST_SKIP
                                                        : i2a_pkg::ST_CONV;
                end
            end
            i2a_pkg::ST_CONV: begin
                if (r_cnt == i2a_pkg::STEP_CNT_W'(i2a_pkg::CONV_STEPS - 1)) begin
                    n_state = i2a_pkg::ST_SKIP;
                end
            end
            i2a_pkg::ST_SKIP: begin
                if (i_digit == '0 && r_idx != '0) begin
                    n_state = i2a_pkg::ST_SKIP;
                end else if (r_hex || r_neg) begin
                    n_state = i2a_pkg::ST_PRE0;
                end else begin
                    n_state = i2a_pkg::ST_DIGIT;
                end
            end
            i2a_pkg::ST_PRE0: begin
                if (out_free) begin
                    n_state = r_hex ? i2a_pkg::ST_PRE1 : i2a_pkg::ST_DIGIT;
                end
            end
            i2a_pkg::ST_PRE1: begin
                if (out_free) begin
                    n_state = i2a_pkg::ST_DIGIT;
                end
            end
            i2a_pkg::ST_DIGIT: begin
                if (out_free && r_idx == '0) begin
                    n_state = i2a_pkg::ST_IDLE;
                end
            end
            default: n_state = i2a_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb begin
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_hex     = r_hex;
        n_neg     = r_neg;
        o_ctl     = '0;
        o_value   = i_in.value;
        emit      = 1'b0;
        emit_ch   = i2a_pkg::CH_ZERO;
        emit_last = 1'b0;
        unique case (r_state)
            i2a_pkg::ST_IDLE: begin
                n_cnt = '0;
                n_idx = IDX_W'(DIGIT_SLOTS - 1);
                if (accept) begin
                    n_hex          = (cmd == i2a_pkg::CMD_HEX);
                    n_neg          = in_neg;
                    o_ctl.load_hex = (cmd == i2a_pkg::CMD_HEX);
                    o_ctl.load_dec = (cmd == i2a_pkg::CMD_UDEC) ||
                                     (cmd == i2a_pkg::CMD_SDEC);
                    // two's complement magnitude of a negative signed operand
                    if (in_neg) begin
                        o_value = (~i_in.value) + 64'd1;
                    end
                end
            end
            i2a_pkg::ST_CONV: begin
                o_ctl.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
            end
            i2a_pkg::ST_SKIP: begin
                // drop leading zero digits, keep at least one
                if (i_digit == '0 && r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                end
            end
            i2a_pkg::ST_PRE0: begin
                emit    = out_free;
                emit_ch = r_hex ? i2a_pkg::CH_ZERO : i2a_pkg::CH_MINUS;
            end
            i2a_pkg::ST_PRE1: begin
                emit    = out_free;
                emit_ch = i2a_pkg::CH_X;
            end
            i2a_pkg::ST_DIGIT: begin
                emit      = out_free;
                emit_ch   = i2a_pkg::glyph(i_digit);
                emit_last = (r_idx == '0);
                if (out_free && r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2a_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_idx <= n_idx;
        r_hex <= n_hex;
        r_neg <= n_neg;
        if (emit) begin
            r_ch   <= emit_ch;
            r_last <= emit_last;
        end
    end

    assign o_sel       = r_idx;
    assign i_in.ready  = (r_state == i2a_pkg::ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.ch    = r_ch;
    assign o_out.last  = r_last;

endmodule

// ===== design/integer_to_ascii_formatter_top.sv =====
// top level of the integer to ascii formatter
//
//  channel  | dir | payload        | handshake
//  ---------+-----+----------------+-------------
//  i_in     | in  | cmd, value     | valid/ready
//  o_out    | out | ch, last       | valid/ready
//
// decimal: the number is accepted, converted two bits per cycle through the shared
// shift-and-add-3 unit, scanned past its leading zero digits, then emitted
// character by character, with a minus sign first for a negative signed operand.
// hex loads the nibbles directly and scans from the top slot.
// ready is high only while idle; an undefined mode is taken and dropped.
// one-deep output register, a stall holds the sequencer; sync active-low reset clears state.
module integer_to_ascii_formatter_top #(
    parameter int DIGIT_SLOTS = i2a_pkg::DIGIT_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2a_in_if.sink      i_in,
    i2a_out_if.source   o_out
);

    localparam int IDX_W = $clog2(DIGIT_SLOTS);

    i2a_pkg::t_unit_ctl            unit_ctl;
    logic [i2a_pkg::VALUE_W-1:0]   unit_value;
    logic [IDX_W-1:0]              unit_sel;
    logic [i2a_pkg::DIGIT_W-1:0]   unit_digit;

    i2a_seq #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_ctl   (unit_ctl),
        .o_value (unit_value),
        .o_sel   (unit_sel),
        .i_digit (unit_digit)
    );

    i2a_bcd_unit #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_bcd_unit (
        .i_clk   (i_clk),
        .i_ctl   (unit_ctl),
        .i_value (unit_value),
        .i_sel   (unit_sel),
        .o_digit (unit_digit)
    );

endmodule

// ===== design/i2a_checker.sv =====
// port-level checks for the formatter, bound to the top level
module i2a_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [i2a_pkg::CMD_W-1:0]     i_in_cmd,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [i2a_pkg::CHAR_W-1:0]    i_out_ch,
    input logic                          i_out_last
);

    logic in_xfer;
    assign in_xfer = i_in_valid && i_in_ready;

    // a real conversion keeps the input closed on the next cycle
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_cmd != i2a_pkg::CMD_NONE |=> !i_in_ready)
        else $error("input still ready right after a conversion started");

    // an undefined mode is dropped and the input stays open
    a_idle_after_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_cmd == i2a_pkg::CMD_NONE |=> i_in_ready)
        else $error("undefined mode left the block busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_ch) && $stable(i_out_last))
        else $error("stalled output transfer changed");

    // only digits, upper-case hex letters, minus and x ever leave
    a_out_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_ch >= 8'h30 && i_out_ch <= 8'h39) ||
            (i_out_ch >= 8'h41 && i_out_ch <= 8'h46) ||
            i_out_ch == i2a_pkg::CH_MINUS || i_out_ch == i2a_pkg::CH_X)
        else $error("unexpected output character");

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_ch    (o_out.ch),
    .i_out_last  (o_out.last)
);

// ===== tb/sv/tb_integer_to_ascii_formatter_top.sv =====
// testbench for the integer to ascii formatter: predicted text checked per character
module tb_integer_to_ascii_formatter_top;

    typedef struct {
        logic [i2a_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } t_char_exp;

    // predicts the text of each accepted number and checks characters in order
    class ascii_scoreboard;
        t_char_exp expected_chars[$];
        int        mismatches;

        function int pending();
            return expected_chars.size();
        endfunction

        function void note_request(i2a_pkg::t_cmd mode,
                                   logic [i2a_pkg::VALUE_W-1:0] operand);
            string                       glyphs;
            logic [i2a_pkg::VALUE_W-1:0] mag;
            logic [3:0]                  digits[$];
            logic [i2a_pkg::CHAR_W-1:0]  text[$];
            t_char_exp                   e;
            glyphs = "0123456789ABCDEF";
            if (mode == i2a_pkg::CMD_NONE) return;
            mag = operand;
            if (mode == i2a_pkg::CMD_HEX) begin
                text.push_back("0");
                text.push_back("x");
                do begin
                    digits.push_front(mag[3:0]);
                    mag = mag >> 4;
                end while (mag != 0);
            end else begin
                if (mode == i2a_pkg::CMD_SDEC && operand[i2a_pkg::VALUE_W-1]) begin
                    text.push_back("-");
                    mag = -operand;
                end
                do begin
                    digits.push_front(4'(mag % 10));
                    mag = mag / 10;
                end while (mag != 0);
            end
            foreach (digits[i]) text.push_back(glyphs[digits[i]]);
            foreach (text[i]) begin
                e.ch   = text[i];
                e.last = (i == text.size() - 1);
                expected_chars.push_back(e);
            end
        endfunction

        function void check_char(logic [i2a_pkg::CHAR_W-1:0] ch, logic last);
            t_char_exp e;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected character %h last %b", ch, last);
                return;
            end
            e = expected_chars.pop_front();
            if (e.ch !== ch || e.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("character mismatch: expected %h last %b, got %h last %b",
                             e.ch, e.last, ch, last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    i2a_in_if  in_ch();
    i2a_out_if out_ch();

    integer_to_ascii_formatter_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ascii_scoreboard scoreboard = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;

    always #2 clk = ~clk;

    function automatic i2a_pkg::t_cmd pick_cmd();
        int r;
        r = $urandom_range(15);
        if (r == 0) return i2a_pkg::CMD_NONE;
        return i2a_pkg::t_cmd'(2'(r % 3));
    endfunction

    function automatic logic [i2a_pkg::VALUE_W-1:0] pick_operand();
        logic [i2a_pkg::VALUE_W-1:0] p;
        int                          k;
        p = 64'd1;
        case ($urandom_range(4))
            0, 1: return {$urandom, $urandom};
            2: return 64'($urandom_range(999));
            3: begin
                // powers of ten and one below them hit the digit count boundaries
                k = $urandom_range(19);
                repeat (k) p = p * 10;
                return p - 64'($urandom_range(1));
            end
            default: begin
                p = p << $urandom_range(63);
                return $urandom_range(1) ? p : -p;
            end
        endcase
    endfunction

    task automatic send_request(input i2a_pkg::t_cmd mode,
                                input logic [i2a_pkg::VALUE_W-1:0] operand);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= mode;
        in_ch.value <= operand;
        do @(posedge clk); while (!in_ch.ready);
        scoreboard.note_request(mode, operand);
    endtask

    // stop offering and let every outstanding character come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial begin : result_sink
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                scoreboard.check_char(out_ch.ch, out_ch.last);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin : stimulus
        int send_pcts[4];
        int stall_pcts[4];
        send_pcts  = '{0, 85, 0, 27};
        stall_pcts = '{0, 0, 85, 27};
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.cmd   <= i2a_pkg::CMD_UDEC;
        in_ch.value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(i2a_pkg::CMD_UDEC, 64'd0);
        send_request(i2a_pkg::CMD_UDEC, 64'd1);
        send_request(i2a_pkg::CMD_UDEC, 64'd9);
        send_request(i2a_pkg::CMD_UDEC, 64'd10);
        send_request(i2a_pkg::CMD_UDEC, 64'd10000000000000000000);
        send_request(i2a_pkg::CMD_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(i2a_pkg::CMD_SDEC, 64'd0);
        send_request(i2a_pkg::CMD_SDEC, 64'h8000_0000_0000_0000);
        send_request(i2a_pkg::CMD_SDEC, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(i2a_pkg::CMD_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(i2a_pkg::CMD_SDEC, -64'd10);
        send_request(i2a_pkg::CMD_HEX, 64'd0);
        send_request(i2a_pkg::CMD_HEX, 64'hA);
        send_request(i2a_pkg::CMD_HEX, 64'h0123_4567_89AB_CDEF);
        send_request(i2a_pkg::CMD_HEX, 64'h8000_0000_0000_0000);
        send_request(i2a_pkg::CMD_HEX, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(i2a_pkg::CMD_NONE, 64'd0);
        send_request(i2a_pkg::CMD_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pcts[p];
            stall_pct     = stall_pcts[p];
            // long receiver hold-off while the sender keeps offering
            if (p == 0) hold_left = 300;
            for (int i = 0; i < 28; i++) begin
                if (p == 1 && i == 14) drain();
                send_request(pick_cmd(), pick_operand());
            end
            drain();
        end

        if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== integer_to_ascii_formatter_top.f =====
design/i2a_pkg.sv
design/i2a_in_if.sv
design/i2a_out_if.sv
design/i2a_bcd_unit.sv
design/i2a_seq.sv
design/integer_to_ascii_formatter_top.sv
design/i2a_checker.sv
tb/sv/tb_integer_to_ascii_formatter_top.sv
